>>> hw/rtl/gtp_pkg.sv
// Shared types, constants and character helpers for the GUID text parser.
package gtp_pkg;

	localparam int unsigned POS_W = 6;
	localparam int unsigned CHAR_W = 8;
	localparam int unsigned NIBBLE_W = 4;
	localparam int unsigned VALUE_W = 128;
	localparam int unsigned HALF_W = 64;

	localparam logic [POS_W-1:0] POS_MAX = 6'd63;
	localparam logic [POS_W-1:0] PLAIN_LEN = 6'd32;
	localparam logic [POS_W-1:0] DASHED_LEN = 6'd36;
	localparam logic [POS_W-1:0] WRAPPED_LEN = 6'd38;
	localparam logic [POS_W-1:0] PLAIN_END = PLAIN_LEN - 6'd1;
	localparam logic [POS_W-1:0] DASHED_END = DASHED_LEN - 6'd1;
	localparam logic [POS_W-1:0] WRAPPED_END = WRAPPED_LEN - 6'd1;
	localparam logic [POS_W-1:0] SEP_0 = 6'd8;
	localparam logic [POS_W-1:0] SEP_1 = 6'd13;
	localparam logic [POS_W-1:0] SEP_2 = 6'd18;
	localparam logic [POS_W-1:0] SEP_3 = 6'd23;

	localparam logic [CHAR_W-1:0] CH_DASH = 8'h2D;
	localparam logic [CHAR_W-1:0] CH_LBRACE = 8'h7B;
	localparam logic [CHAR_W-1:0] CH_RBRACE = 8'h7D;
	localparam logic [CHAR_W-1:0] CH_LPAREN = 8'h28;
	localparam logic [CHAR_W-1:0] CH_RPAREN = 8'h29;

	typedef enum logic [1:0] {
		KIND_NONE  = 2'd0,
		KIND_BRACE = 2'd1,
		KIND_PAREN = 2'd2
	} open_kind_t;

	typedef struct packed {
		logic                is_hex;
		logic [NIBBLE_W-1:0] nibble;
		logic                is_dash;
		logic                is_lbrace;
		logic                is_rbrace;
		logic                is_lparen;
		logic                is_rparen;
	} char_class_t;

	typedef struct packed {
		logic               ok;
		logic [VALUE_W-1:0] value;
	} parse_result_t;

endpackage

>>> hw/rtl/gtp_char_class.sv
// Character classifier: hex digit value and the punctuation the GUID forms use.
module gtp_char_class
	import gtp_pkg::*;
(
	input  logic [CHAR_W-1:0] char_code,
	output char_class_t       cls
);

	logic [CHAR_W-1:0] digit_off;

	always_comb begin
		digit_off = '0;
		cls = '0;
		if (char_code inside {[8'h30:8'h39]}) begin
			digit_off = char_code - 8'h30;
			cls.is_hex = 1'b1;
			cls.nibble = digit_off[NIBBLE_W-1:0];
		end else if (char_code inside {[8'h61:8'h66]}) begin
			digit_off = char_code - 8'h57;
			cls.is_hex = 1'b1;
			cls.nibble = digit_off[NIBBLE_W-1:0];
		end else if (char_code inside {[8'h41:8'h46]}) begin
			digit_off = char_code - 8'h37;
			cls.is_hex = 1'b1;
			cls.nibble = digit_off[NIBBLE_W-1:0];
		end
		cls.is_dash = (char_code == CH_DASH);
		cls.is_lbrace = (char_code == CH_LBRACE);
		cls.is_rbrace = (char_code == CH_RBRACE);
		cls.is_lparen = (char_code == CH_LPAREN);
		cls.is_rparen = (char_code == CH_RPAREN);
	end

endmodule

>>> hw/rtl/gtp_parse_core.sv
// Per-text parse state: position, form checks and the digit accumulator.
module gtp_parse_core
	import gtp_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          step,
	input  logic          is_last,
	input  char_class_t   cls,
	output parse_result_t res
);

	logic [POS_W-1:0]   pos_q;
	open_kind_t         kind_q;
	logic               plain_ok_q;
	logic               dashed_ok_q;
	logic               wrapped_ok_q;
	logic [VALUE_W-1:0] acc_q;

	logic [POS_W-1:0]   pos_d;
	open_kind_t         kind_d;
	logic               plain_ok_d;
	logic               dashed_ok_d;
	logic               wrapped_ok_d;
	logic [VALUE_W-1:0] acc_d;
	logic               sep_cur;
	logic               sep_prev;
	logic               fits_cur;
	logic               fits_prev;
	logic               closer_ok;

	always_comb begin
		sep_cur = (pos_q inside {SEP_0, SEP_1, SEP_2, SEP_3});
		sep_prev = (pos_q inside {SEP_0 + 6'd1, SEP_1 + 6'd1, SEP_2 + 6'd1, SEP_3 + 6'd1});
		fits_cur = sep_cur ? cls.is_dash : cls.is_hex;
		fits_prev = sep_prev ? cls.is_dash : cls.is_hex;

		plain_ok_d = plain_ok_q;
		dashed_ok_d = dashed_ok_q;
		wrapped_ok_d = wrapped_ok_q;
		kind_d = kind_q;
		closer_ok = 1'b0;

		if (pos_q < PLAIN_LEN && !cls.is_hex) begin
			plain_ok_d = 1'b0;
		end
		if (pos_q < DASHED_LEN && !fits_cur) begin
			dashed_ok_d = 1'b0;
		end

		if (pos_q == '0) begin
			if (cls.is_lbrace) begin
				kind_d = KIND_BRACE;
			end else if (cls.is_lparen) begin
				kind_d = KIND_PAREN;
			end else begin
				kind_d = KIND_NONE;
				wrapped_ok_d = 1'b0;
			end
		end else if (pos_q <= DASHED_LEN) begin
			if (!fits_prev) begin
				wrapped_ok_d = 1'b0;
			end
		end else if (pos_q == WRAPPED_END) begin
			closer_ok = (kind_q == KIND_BRACE && cls.is_rbrace) ||
				(kind_q == KIND_PAREN && cls.is_rparen);
		end

		acc_d = acc_q;
		if (cls.is_hex) begin
			acc_d = {acc_q[VALUE_W-NIBBLE_W-1:0], cls.nibble};
		end

		pos_d = (pos_q == POS_MAX) ? pos_q : pos_q + 6'd1;

		res.ok = (pos_q == PLAIN_END && plain_ok_d) ||
			(pos_q == DASHED_END && dashed_ok_d) ||
			(pos_q == WRAPPED_END && wrapped_ok_d && closer_ok);
		res.value = res.ok ? acc_d : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			kind_q <= KIND_NONE;
			plain_ok_q <= 1'b1;
			dashed_ok_q <= 1'b1;
			wrapped_ok_q <= 1'b1;
			acc_q <= '0;
		end else if (step) begin
			if (is_last) begin
				pos_q <= '0;
				kind_q <= KIND_NONE;
				plain_ok_q <= 1'b1;
				dashed_ok_q <= 1'b1;
				wrapped_ok_q <= 1'b1;
				acc_q <= '0;
			end else begin
				pos_q <= pos_d;
				kind_q <= kind_d;
				plain_ok_q <= plain_ok_d;
				dashed_ok_q <= dashed_ok_d;
				wrapped_ok_q <= wrapped_ok_d;
				acc_q <= acc_d;
			end
		end
	end

endmodule

>>> hw/rtl/guid_text_parser_top.sv
// Top level of the GUID text parser with its stream handshakes.
//
// The slave stream carries one text character per request, the ASCII code
// in s_tdata and s_tlast on the final character of the text.  Plain,
// dashed and braced or parenthesized dashed forms are accepted.  The master
// stream gives one request per text, after its final character: m_tuser is
// the valid flag and m_tdata the 128-bit value, zero when invalid.
// A character is taken every cycle except while a final character is held
// back as described below.  It is registered at the input, the parse state
// and the result are worked out in the next cycle, and the result register
// shows the request after the final character leaves the input register.
// Two registers, input and result, lie between a final character and its request.
// When the receiver stalls, characters that give no result are still taken
// while a result waits; only a final character stops in the input register
// until the waiting result is taken, and s_tready then goes low.
// Reset clears the position and both valid flags and sets the form checks, so the
// next character starts a new text.
module guid_text_parser_top
	import gtp_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [CHAR_W-1:0]  s_tdata,  // [7:0] char_code
	input  logic               s_tlast,  // is_last
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [VALUE_W-1:0] m_tdata,  // [63:0] value_high, [127:64] value_low
	output logic               m_tuser   // valid_res
);

	logic              valid_s1;
	logic [CHAR_W-1:0] char_s1;
	logic              last_s1;
	logic              out_valid_q;
	logic              out_ok_q;
	logic [VALUE_W-1:0] out_value_q;
	logic              adv_s1;
	logic              step;
	char_class_t       cls;
	parse_result_t     res;

	assign adv_s1 = !(last_s1 && out_valid_q && !m_tready);
	assign s_tready = !valid_s1 || adv_s1;
	assign step = valid_s1 && adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			char_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	gtp_char_class u_class (
		.char_code(char_s1),
		.cls(cls)
	);

	gtp_parse_core u_core (
		.clk(clk),
		.arst_n(arst_n),
		.step(step),
		.is_last(last_s1),
		.cls(cls),
		.res(res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && last_s1) begin
			out_ok_q <= res.ok;
			out_value_q <= res.value;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser = out_ok_q;
	assign m_tdata = {out_value_q[HALF_W-1:0], out_value_q[VALUE_W-1:HALF_W]};

endmodule

>>> hw/rtl/gtp_checker.sv
// Port-level checker for the GUID text parser and its bind to the top level.
module gtp_checker
	import gtp_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               s_tvalid,
	input logic               s_tready,
	input logic               s_tlast,
	input logic               m_tvalid,
	input logic               m_tready,
	input logic [VALUE_W-1:0] m_tdata,
	input logic               m_tuser
);

	logic in_last_acc;

	assign in_last_acc = s_tvalid && s_tready && s_tlast;

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result request changed while stalled");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata == '0)
		else $error("invalid text gave a nonzero value");

	a_result_follows_last: assert property (@(posedge clk) disable iff (!arst_n)
		in_last_acc && !m_tvalid |=> ##1 m_tvalid)
		else $error("no result request after a final character");

	a_ready_only_on_backlog: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("input stalled with no result waiting");

endmodule

bind guid_text_parser_top gtp_checker u_gtp_checker (
	.clk(clk),
	.arst_n(arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.s_tlast(s_tlast),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata(m_tdata),
	.m_tuser(m_tuser)
);

>>> test/guid_text_parser_top_tb.sv
// Self-checking testbench for the GUID text parser top level.
`timescale 1ns / 1ps

module guid_text_parser_top_tb;
	import gtp_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int RANDOM_CHARS = 150;
	localparam int RANDOM_TEXTS = 4;
	localparam int HOLD_AT = 12;
	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN_CYCLES = 20;

	typedef struct packed {
		logic               ok;
		logic [HALF_W-1:0]  high;
		logic [HALF_W-1:0]  low;
	} guid_result_t;

	typedef enum int {FORM_PLAIN, FORM_DASHED, FORM_BRACED, FORM_PARENS} guid_form_t;
	typedef enum int {DMG_REPLACE, DMG_DROP, DMG_INSERT, DMG_CLOSER} damage_t;

	localparam guid_result_t REJECT = '0;
	localparam guid_result_t ALL_ZERO = {1'b1, {VALUE_W{1'b0}}};
	localparam guid_result_t ALL_ONES = {1'b1, {VALUE_W{1'b1}}};

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               s_tvalid = 1'b0;
	logic               s_tready;
	logic [CHAR_W-1:0]  s_tdata = '0;
	logic               s_tlast = 1'b0;
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	logic [VALUE_W-1:0] m_tdata;
	logic               m_tuser;

	// Parser state as seen by the predictor.
	logic [POS_W-1:0]   char_pos = '0;
	open_kind_t         open_kind = KIND_NONE;
	logic               plain_ok = 1'b1;
	logic               dashed_ok = 1'b1;
	logic               wrapped_ok = 1'b1;
	logic [VALUE_W-1:0] digits = '0;

	guid_result_t       pending_guids[$];
	logic [CHAR_W-1:0]  text_buf[$];
	string              dir_text[$];
	bit                 dir_typed[$];
	guid_result_t       dir_want[$];

	int errors = 0;
	int cycles = 0;
	int input_stalls = 0;
	int texts_sent = 0;
	int chars_sent = 0;
	int results_seen = 0;
	int valid_seen = 0;

	guid_text_parser_top DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (s_tvalid && !s_tready) begin
			input_stalls <= input_stalls + 1;
		end
		if (cycles == CYCLE_LIMIT) begin
			$display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Value 0 to 15 for a hex digit, 16 for anything else.
	function automatic logic [4:0] digit_of(input logic [CHAR_W-1:0] c);
		if (c >= 8'h30 && c <= 8'h39) begin
			return 5'(c - 8'h30);
		end
		if (c >= 8'h61 && c <= 8'h66) begin
			return 5'(c - 8'h61 + 8'd10);
		end
		if (c >= 8'h41 && c <= 8'h46) begin
			return 5'(c - 8'h41 + 8'd10);
		end
		return 5'd16;
	endfunction

	function automatic logic fits_dashed(input logic [POS_W-1:0] p, input logic [CHAR_W-1:0] c,
			input logic is_hex);
		if (p == SEP_0 || p == SEP_1 || p == SEP_2 || p == SEP_3) begin
			return c == CH_DASH;
		end
		return is_hex;
	endfunction

	task automatic parse_char(input logic [CHAR_W-1:0] c, input logic last, output logic done,
			output guid_result_t res);
		logic [4:0]       d;
		logic             is_hex;
		logic             closer_ok;
		logic [POS_W-1:0] p;
		p = char_pos;
		d = digit_of(c);
		is_hex = ~d[4];
		closer_ok = 1'b0;
		done = 1'b0;
		res = REJECT;
		if (p < PLAIN_LEN && !is_hex) begin
			plain_ok = 1'b0;
		end
		if (p < DASHED_LEN && !fits_dashed(p, c, is_hex)) begin
			dashed_ok = 1'b0;
		end
		if (p == '0) begin
			case (c)
				CH_LBRACE: open_kind = KIND_BRACE;
				CH_LPAREN: open_kind = KIND_PAREN;
				default: begin
					open_kind = KIND_NONE;
					wrapped_ok = 1'b0;
				end
			endcase
		end else if (p <= DASHED_LEN) begin
			if (!fits_dashed(p - 6'd1, c, is_hex)) begin
				wrapped_ok = 1'b0;
			end
		end else if (p == WRAPPED_END) begin
			closer_ok = (open_kind == KIND_BRACE && c == CH_RBRACE) ||
				(open_kind == KIND_PAREN && c == CH_RPAREN);
		end
		if (is_hex) begin
			digits = {digits[VALUE_W-NIBBLE_W-1:0], d[NIBBLE_W-1:0]};
		end
		if (!last) begin
			if (char_pos != POS_MAX) begin
				char_pos = char_pos + 6'd1;
			end
		end else begin
			done = 1'b1;
			res.ok = (p == PLAIN_END && plain_ok) || (p == DASHED_END && dashed_ok) ||
				(p == WRAPPED_END && wrapped_ok && closer_ok);
			if (res.ok) begin
				{res.high, res.low} = digits;
			end
			char_pos = '0;
			open_kind = KIND_NONE;
			plain_ok = 1'b1;
			dashed_ok = 1'b1;
			wrapped_ok = 1'b1;
			digits = '0;
		end
	endtask

	// Offers the text in text_buf one character per request.
	task automatic send_text(input bit typed, input guid_result_t want);
		guid_result_t got;
		logic         done;
		logic         last;
		bit           quick;
		int           gap;
		quick = ($urandom_range(0, 2) == 0);
		foreach (text_buf[i]) begin
			gap = quick ? 0 : $urandom_range(0, 12);
			last = (i == text_buf.size() - 1);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			s_tvalid <= 1'b1;
			s_tdata <= text_buf[i];
			s_tlast <= last;
			@(posedge clk);
			while (!s_tready) @(posedge clk);
			parse_char(text_buf[i], last, done, got);
			chars_sent++;
			if (done) begin
				pending_guids.insert(pending_guids.size(), typed ? want : got);
			end
		end
		texts_sent++;
	endtask

	task automatic put_hex(input int n);
		int v;
		repeat (n) begin
			v = $urandom_range(0, 15);
			if (v < 10) begin
				text_buf.insert(text_buf.size(), 8'(8'h30 + v));
			end else begin
				text_buf.insert(text_buf.size(),
					8'(($urandom_range(0, 1) ? 8'h61 : 8'h41) + v - 10));
			end
		end
	endtask

	task automatic build_guid(input guid_form_t form);
		text_buf.delete();
		if (form == FORM_BRACED) begin
			text_buf.insert(text_buf.size(), CH_LBRACE);
		end else if (form == FORM_PARENS) begin
			text_buf.insert(text_buf.size(), CH_LPAREN);
		end
		if (form == FORM_PLAIN) begin
			put_hex(32);
		end else begin
			put_hex(8);
			text_buf.insert(text_buf.size(), CH_DASH);
			put_hex(4);
			text_buf.insert(text_buf.size(), CH_DASH);
			put_hex(4);
			text_buf.insert(text_buf.size(), CH_DASH);
			put_hex(4);
			text_buf.insert(text_buf.size(), CH_DASH);
			put_hex(12);
		end
		if (form == FORM_BRACED) begin
			text_buf.insert(text_buf.size(), CH_RBRACE);
		end else if (form == FORM_PARENS) begin
			text_buf.insert(text_buf.size(), CH_RPAREN);
		end
	endtask

	task automatic damage_text;
		logic [CHAR_W-1:0] closers[3];
		int                pos;
		closers = '{CH_RBRACE, CH_RPAREN, CH_LBRACE};
		pos = $urandom_range(0, text_buf.size() - 1);
		case (damage_t'($urandom_range(0, 3)))
			DMG_REPLACE: text_buf[pos] = 8'($urandom_range(0, 255));
			DMG_DROP: text_buf.delete(pos);
			DMG_INSERT: text_buf.insert(pos, 8'($urandom_range(0, 255)));
			DMG_CLOSER: text_buf[text_buf.size() - 1] = closers[$urandom_range(0, 2)];
			default: ;
		endcase
	endtask

	task automatic add_row(input string text, input bit typed, input guid_result_t want);
		dir_text.insert(dir_text.size(), text);
		dir_typed.insert(dir_typed.size(), typed);
		dir_want.insert(dir_want.size(), want);
	endtask

	// Result side: random stalls, one long hold so that the input backs up.
	initial begin
		guid_result_t want;
		int           gap;
		bit           quick;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (results_seen % 8 == 0) begin
				quick = ($urandom_range(0, 2) == 0);
			end
			gap = quick ? 0 : $urandom_range(0, 12);
			if (results_seen == HOLD_AT) begin
				gap = HOLD_CYCLES;
			end
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
			results_seen++;
			if (m_tuser) begin
				valid_seen++;
			end
			if (pending_guids.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, valid_res %b value %h", $time, m_tuser, m_tdata);
			end else begin
				want = pending_guids.pop_front();
				if (m_tuser !== want.ok) begin
					errors++;
					$display("%0t: valid_res expected %b, got %b", $time, want.ok, m_tuser);
				end
				if (m_tdata[63:0] !== want.high) begin
					errors++;
					$display("%0t: value_high expected %h, got %h", $time, want.high,
						m_tdata[63:0]);
				end
				if (m_tdata[127:64] !== want.low) begin
					errors++;
					$display("%0t: value_low expected %h, got %h", $time, want.low,
						m_tdata[127:64]);
				end
			end
		end
	end

	initial begin
		int pick;
		int rnd_chars;
		int rnd_texts;
		add_row("00000000000000000000000000000000", 1'b1, ALL_ZERO);
		add_row("ffffffffffffffffffffffffffffffff", 1'b1, ALL_ONES);
		add_row("FFFFFFFF-FFFF-FFFF-FFFF-FFFFFFFFFFFF", 1'b1, ALL_ONES);
		add_row("0123456789abcdefABCDEF0123456789", 1'b0, REJECT);
		add_row("a1b2c3d4-e5f6-a7b8-c9d0-e1f2a3b4c5d6", 1'b0, REJECT);
		add_row("{01234567-89ab-cdef-0123-456789ABCDEF}", 1'b0, REJECT);
		add_row("(fedcba98-7654-3210-FEDC-BA9876543210)", 1'b0, REJECT);
		add_row("{01234567-89ab-cdef-0123-456789ABCDEF)", 1'b1, REJECT);
		add_row("(01234567-89ab-cdef-0123-456789ABCDEF}", 1'b1, REJECT);
		add_row("[01234567-89ab-cdef-0123-456789ABCDEF]", 1'b1, REJECT);
		add_row("x01234567-89ab-cdef-0123-456789abcdef}", 1'b1, REJECT);
		add_row("{01234567-89ab-cdef-0123-456789ABCDEF}0", 1'b1, REJECT);
		add_row({"0123456789abcdef0123456789abcdef0123456789abcdef",
			"0123456789abcdef0123456789abcdef"}, 1'b1, REJECT);
		add_row("a", 1'b1, REJECT);
		add_row("0123456789abcdef0123456789abcde", 1'b1, REJECT);
		add_row("0123456789abcdef0123456789abcdef0", 1'b1, REJECT);
		add_row("01234567-89ab-cdef-0123-456789abcde", 1'b1, REJECT);
		add_row("{01234567-89ab-cdef-0123-456789abcdef", 1'b1, REJECT);
		add_row("012345678-9ab-cdef-0123-456789abcdef", 1'b1, REJECT);
		add_row("/:@GJ`gz0123456789abcdef01234567", 1'b1, REJECT);
		add_row("{0123456789abcdef0123456789abcdef01}", 1'b1, REJECT);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_text[r]) begin
			text_buf.delete();
			for (int i = 0; i < dir_text[r].len(); i++) begin
				text_buf.insert(text_buf.size(), dir_text[r][i]);
			end
			send_text(dir_typed[r], dir_want[r]);
		end

		// Mostly well-formed GUIDs with random digits, some damaged, some noise.
		rnd_chars = 0;
		rnd_texts = 0;
		while (rnd_chars < RANDOM_CHARS || rnd_texts < RANDOM_TEXTS) begin
			pick = $urandom_range(0, 9);
			if (pick < 6) begin
				build_guid(guid_form_t'(pick % 4));
			end else if (pick < 8) begin
				build_guid(guid_form_t'($urandom_range(0, 3)));
				damage_text();
			end else if (pick == 8) begin
				text_buf.delete();
				repeat ($urandom_range(1, 70)) begin
					text_buf.insert(text_buf.size(), 8'($urandom_range(0, 255)));
				end
			end else begin
				text_buf.delete();
				put_hex($urandom_range(28, 40));
			end
			rnd_chars += text_buf.size();
			rnd_texts++;
			send_text(1'b0, REJECT);
		end
		s_tvalid <= 1'b0;

		while (pending_guids.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d texts, %0d characters: plain, dashed, braced, parenthesized,",
			texts_sent, chars_sent);
		$display("damaged and noise; %0d results checked, %0d valid, %0d input stall cycles.",
			results_seen, valid_seen, input_stalls);
		if (errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

>>> files.f
hw/rtl/gtp_pkg.sv
hw/rtl/gtp_char_class.sv
hw/rtl/gtp_parse_core.sv
hw/rtl/guid_text_parser_top.sv
hw/rtl/gtp_checker.sv
test/guid_text_parser_top_tb.sv
